### sv/pressure_temperature_compensation_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure and temperature compensation block
// Wraps concurrent assertions so that they can be left out of a build.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk, ignored while rst_n is low.
`define PTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Checked on every rising edge of clk, reset included.
`define PTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define PTC_ASSERT(lbl, prop, msg)
`define PTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/ptc_pkg.sv
// ----------------------------------------------------------------------------
// Compensation package
// Shared widths, constants, register indexes, operation codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  // Field widths.
  localparam int unsigned RAW_W   = 20;
  localparam int unsigned TEMP_W  = 24;
  localparam int unsigned PRESS_W = 32;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = ((RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((TEMP_W + PRESS_W + 7) / 8) * 8;

  // Divider: bits retired per cycle and number of steps per division.
  localparam int unsigned DIV_BITS  = 2;
  localparam int unsigned DIV_STEPS = WORD_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Arithmetic constants of the trimming formulas.
  localparam logic [WORD_W-1:0] TEMP_SCALE  = 32'd5;
  localparam logic [WORD_W-1:0] ROUND_BIAS  = 32'd128;
  localparam logic [WORD_W-1:0] FINE_OFFSET = 32'd64000;
  localparam logic [WORD_W-1:0] P1_BIAS     = 32'd32768;
  localparam logic [WORD_W-1:0] ADC_FULL    = 32'd1048576;
  localparam logic [WORD_W-1:0] PRESS_SCALE = 32'd3125;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_COEFFS = 2'd0,
    CFG_PRESS_LOW   = 2'd1,
    CFG_PRESS_HIGH  = 2'd2,
    CFG_PRESS_NINE  = 2'd3
  } cfg_reg_t;

  // Item kinds.
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  // Datapath operations, one per controller step.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_T_DIFF, OP_T_MUL_A, OP_T_SQR, OP_T_MUL_C, OP_T_FINE, OP_T_SCALE, OP_T_ROUND,
    OP_P_V1, OP_P_SQR, OP_P_MUL6, OP_P_MUL5, OP_P_ADD5, OP_P_ADD4, OP_P_MUL3,
    OP_P_MUL2, OP_P_SUM1, OP_P_MUL1, OP_P_BASE, OP_P_MUL3125, OP_P_DIV_GO,
    OP_P_QUOT, OP_P_ZERO, OP_P_SQP, OP_P_MUL9, OP_P_MUL8, OP_P_ADD98, OP_P_ADD7,
    OP_P_FINAL
  } op_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_T_DIFF, S_T_MUL_A, S_T_SQR, S_T_MUL_C, S_T_FINE, S_T_SCALE, S_T_ROUND,
    S_P_V1, S_P_SQR, S_P_MUL6, S_P_MUL5, S_P_ADD5, S_P_ADD4, S_P_MUL3,
    S_P_MUL2, S_P_SUM1, S_P_MUL1, S_P_BASE, S_P_MUL3125, S_P_DIV_GO, S_P_DIV,
    S_P_QUOT, S_P_ZERO, S_P_SQP, S_P_MUL9, S_P_MUL8, S_P_ADD98, S_P_ADD7,
    S_P_FINAL, S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    op_t  op;
    logic capture;
    logic load_out;
  } ptc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_zero;
    logic div_done;
  } ptc_stat_t;

endpackage

`default_nettype wire

### sv/ptc_div.sv
// ----------------------------------------------------------------------------
// Unsigned 32-bit divider
// Restoring division retiring two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pressure_temperature_compensation_macros.svh"

module ptc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ptc_pkg::WORD_W-1:0]  dividend,
  input  wire logic [ptc_pkg::WORD_W-1:0]  divisor,
  output logic      [ptc_pkg::WORD_W-1:0]  quotient,
  output logic                             done
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [ptc_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ptc_pkg::WORD_W-1:0]       rem_r, rem_nxt;
  logic [ptc_pkg::WORD_W-1:0]       quo_r, quo_nxt;
  logic [ptc_pkg::WORD_W-1:0]       den_r, den_nxt;
  logic [ptc_pkg::WORD_W-1:0]       step_rem;
  logic [ptc_pkg::WORD_W-1:0]       step_quo;

  // Two restoring steps: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [ptc_pkg::WORD_W:0] trial;
    step_rem = rem_r;
    step_quo = quo_r;
    for (int i = 0; i < ptc_pkg::DIV_BITS; i++) begin
      trial    = {step_rem, step_quo[ptc_pkg::WORD_W-1]};
      step_quo = {step_quo[ptc_pkg::WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial       = trial - {1'b0, den_r};
        step_quo[0] = 1'b1;
      end
      step_rem = trial[ptc_pkg::WORD_W-1:0];
    end
  end

  // Sequencing of the division.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ptc_pkg::DIV_CNT_W'(ptc_pkg::DIV_STEPS - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = step_rem;
      quo_nxt = step_quo;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

  // A new division never starts on top of one in flight.
  `PTC_ASSERT(a_div_start_idle, start |-> !busy_r, "divider restarted while busy")

endmodule

`default_nettype wire

### sv/ptc_dp.sv
// ----------------------------------------------------------------------------
// Compensation datapath
// Trimming registers, fine temperature, work registers, one shared
// 32x32 multiplier (low word) and the iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ptc_pkg::ptc_cmd_t             cmd,
  output ptc_pkg::ptc_stat_t                 stat,
  input  wire logic                          in_kind,
  input  wire logic [ptc_pkg::RAW_W-1:0]     in_raw,
  input  wire logic                          cfg_we,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ptc_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                               out_kind,
  output logic      [ptc_pkg::TEMP_W-1:0]    out_temp,
  output logic      [ptc_pkg::PRESS_W-1:0]   out_press
);

  typedef logic [ptc_pkg::WORD_W-1:0] word_t;

  // Arithmetic right shift of a 32-bit word.
  function automatic word_t sar(input word_t x, input int unsigned s);
    return word_t'($signed(x) >>> s);
  endfunction

  // Sign extension of a 16-bit coefficient.
  function automatic word_t sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  // Trimming registers and fine temperature.
  logic [47:0]                    tc_r, tc_nxt;
  logic [ptc_pkg::CFG_W-1:0]      pl_r, pl_nxt;
  logic [ptc_pkg::CFG_W-1:0]      ph_r, ph_nxt;
  logic [15:0]                    p9_r, p9_nxt;
  word_t                          fine_r, fine_nxt;

  // Captured item and work registers.
  logic                           kind_r, kind_nxt;
  logic [ptc_pkg::RAW_W-1:0]      raw_r, raw_nxt;
  word_t                          ra_r, ra_nxt;
  word_t                          rb_r, rb_nxt;
  word_t                          rc_r, rc_nxt;
  word_t                          rd_r, rd_nxt;
  word_t                          rp_r, rp_nxt;
  word_t                          res_r, res_nxt;
  logic                           dbl_r, dbl_nxt;
  logic                           okind_r, okind_nxt;
  logic [ptc_pkg::TEMP_W-1:0]     otemp_r, otemp_nxt;
  logic [ptc_pkg::PRESS_W-1:0]    opress_r, opress_nxt;

  // Coefficients as 32-bit words.
  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  word_t mul_a, mul_b, prod;
  word_t adc;
  word_t quot;
  logic  div_start;
  logic  div_done;
  word_t div_dividend;

  assign adc = {{(ptc_pkg::WORD_W - ptc_pkg::RAW_W){1'b0}}, raw_r};
  assign t1  = {16'h0000, tc_r[15:0]};
  assign t2  = sx16(tc_r[31:16]);
  assign t3  = sx16(tc_r[47:32]);
  assign p1  = {16'h0000, pl_r[15:0]};
  assign p2  = sx16(pl_r[31:16]);
  assign p3  = sx16(pl_r[47:32]);
  assign p4  = sx16(pl_r[63:48]);
  assign p5  = sx16(ph_r[15:0]);
  assign p6  = sx16(ph_r[31:16]);
  assign p7  = sx16(ph_r[47:32]);
  assign p8  = sx16(ph_r[63:48]);
  assign p9  = sx16(p9_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      ptc_pkg::OP_T_MUL_A:   begin mul_a = ra_r;             mul_b = t2; end
      ptc_pkg::OP_T_SQR:     begin mul_a = rb_r;             mul_b = rb_r; end
      ptc_pkg::OP_T_MUL_C:   begin mul_a = rb_r;             mul_b = t3; end
      ptc_pkg::OP_T_SCALE:   begin mul_a = fine_r;           mul_b = ptc_pkg::TEMP_SCALE; end
      ptc_pkg::OP_P_SQR:     begin mul_a = sar(ra_r, 2);     mul_b = sar(ra_r, 2); end
      ptc_pkg::OP_P_MUL6:    begin mul_a = sar(rb_r, 11);    mul_b = p6; end
      ptc_pkg::OP_P_MUL5:    begin mul_a = ra_r;             mul_b = p5; end
      ptc_pkg::OP_P_MUL3:    begin mul_a = p3;               mul_b = sar(rb_r, 13); end
      ptc_pkg::OP_P_MUL2:    begin mul_a = p2;               mul_b = ra_r; end
      ptc_pkg::OP_P_MUL1:    begin mul_a = ptc_pkg::P1_BIAS + ra_r; mul_b = p1; end
      ptc_pkg::OP_P_MUL3125: begin mul_a = rb_r;             mul_b = ptc_pkg::PRESS_SCALE; end
      ptc_pkg::OP_P_SQP:     begin mul_a = rp_r >> 3;        mul_b = rp_r >> 3; end
      ptc_pkg::OP_P_MUL9:    begin mul_a = p9;               mul_b = rd_r >> 13; end
      ptc_pkg::OP_P_MUL8:    begin mul_a = rp_r >> 2;        mul_b = p8; end
      default:               begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  // Low word of the product; every step wraps at 32 bits.
  assign prod = mul_a * mul_b;

  // Divider operands: a product with its top bit clear is doubled before
  // division, otherwise the quotient is doubled afterwards.
  assign div_start    = (cmd.op == ptc_pkg::OP_P_DIV_GO);
  assign div_dividend = rb_r[ptc_pkg::WORD_W-1] ? rb_r : {rb_r[ptc_pkg::WORD_W-2:0], 1'b0};

  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ra_r),
    .quotient (quot),
    .done     (div_done)
  );

  // Configuration writes.
  always_comb begin
    tc_nxt = tc_r;
    pl_nxt = pl_r;
    ph_nxt = ph_r;
    p9_nxt = p9_r;
    if (cfg_we) begin
      unique case (ptc_pkg::cfg_reg_t'(cfg_idx))
        ptc_pkg::CFG_TEMP_COEFFS: tc_nxt = cfg_wdata[47:0];
        ptc_pkg::CFG_PRESS_LOW:   pl_nxt = cfg_wdata;
        ptc_pkg::CFG_PRESS_HIGH:  ph_nxt = cfg_wdata;
        ptc_pkg::CFG_PRESS_NINE:  p9_nxt = cfg_wdata[15:0];
      endcase
    end
  end

  // One operation per step of the controller.
  always_comb begin
    kind_nxt   = kind_r;
    raw_nxt    = raw_r;
    fine_nxt   = fine_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    rc_nxt     = rc_r;
    rd_nxt     = rd_r;
    rp_nxt     = rp_r;
    res_nxt    = res_r;
    dbl_nxt    = dbl_r;
    okind_nxt  = okind_r;
    otemp_nxt  = otemp_r;
    opress_nxt = opress_r;

    if (cmd.capture) begin
      kind_nxt = in_kind;
      raw_nxt  = in_raw;
    end

    case (cmd.op)
      // Temperature polynomial.
      ptc_pkg::OP_T_DIFF: begin
        ra_nxt = (adc >> 3) - (t1 << 1);
        rb_nxt = (adc >> 4) - t1;
      end
      ptc_pkg::OP_T_MUL_A:   ra_nxt   = sar(prod, 11);
      ptc_pkg::OP_T_SQR:     rb_nxt   = sar(prod, 12);
      ptc_pkg::OP_T_MUL_C:   rb_nxt   = sar(prod, 14);
      ptc_pkg::OP_T_FINE:    fine_nxt = ra_r + rb_r;
      ptc_pkg::OP_T_SCALE:   ra_nxt   = prod;
      ptc_pkg::OP_T_ROUND:   res_nxt  = sar(ra_r + ptc_pkg::ROUND_BIAS, 8);
      // Pressure: divisor and dividend terms.
      ptc_pkg::OP_P_V1:      ra_nxt   = sar(fine_r, 1) - ptc_pkg::FINE_OFFSET;
      ptc_pkg::OP_P_SQR:     rb_nxt   = prod;
      ptc_pkg::OP_P_MUL6:    rc_nxt   = prod;
      ptc_pkg::OP_P_MUL5:    rd_nxt   = prod;
      ptc_pkg::OP_P_ADD5:    rc_nxt   = rc_r + (rd_r << 1);
      ptc_pkg::OP_P_ADD4:    rc_nxt   = sar(rc_r, 2) + (p4 << 16);
      ptc_pkg::OP_P_MUL3:    rd_nxt   = prod;
      ptc_pkg::OP_P_MUL2:    rb_nxt   = prod;
      ptc_pkg::OP_P_SUM1:    ra_nxt   = sar(sar(rd_r, 3) + sar(rb_r, 1), 18);
      ptc_pkg::OP_P_MUL1:    ra_nxt   = sar(prod, 15);
      ptc_pkg::OP_P_BASE:    rb_nxt   = (ptc_pkg::ADC_FULL - adc) - sar(rc_r, 12);
      ptc_pkg::OP_P_MUL3125: rb_nxt   = prod;
      ptc_pkg::OP_P_DIV_GO:  dbl_nxt  = rb_r[ptc_pkg::WORD_W-1];
      ptc_pkg::OP_P_QUOT:    rp_nxt   = dbl_r ? (quot << 1) : quot;
      ptc_pkg::OP_P_ZERO:    res_nxt  = '0;
      // Pressure: second-order correction.
      ptc_pkg::OP_P_SQP:     rd_nxt   = prod;
      ptc_pkg::OP_P_MUL9:    rd_nxt   = sar(prod, 12);
      ptc_pkg::OP_P_MUL8:    rc_nxt   = sar(prod, 13);
      ptc_pkg::OP_P_ADD98:   rd_nxt   = rd_r + rc_r;
      ptc_pkg::OP_P_ADD7:    rd_nxt   = sar(rd_r + p7, 4);
      ptc_pkg::OP_P_FINAL:   res_nxt  = rp_r + rd_r;
      default: ;
    endcase

    // Result beat into the output register.
    if (cmd.load_out) begin
      okind_nxt = kind_r;
      if (kind_r == ptc_pkg::KIND_PRESS) begin
        otemp_nxt  = '0;
        opress_nxt = res_r;
      end else begin
        otemp_nxt  = res_r[ptc_pkg::TEMP_W-1:0];
        opress_nxt = '0;
      end
    end
  end

  // Registers with a defined reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r   <= '0;
      pl_r   <= '0;
      ph_r   <= '0;
      p9_r   <= '0;
      fine_r <= '0;
    end else begin
      tc_r   <= tc_nxt;
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      p9_r   <= p9_nxt;
      fine_r <= fine_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    raw_r    <= raw_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    rc_r     <= rc_nxt;
    rd_r     <= rd_nxt;
    rp_r     <= rp_nxt;
    res_r    <= res_nxt;
    dbl_r    <= dbl_nxt;
    okind_r  <= okind_nxt;
    otemp_r  <= otemp_nxt;
    opress_r <= opress_nxt;
  end

  assign stat.div_zero = (ra_r == '0);
  assign stat.div_done = div_done;
  assign out_kind      = okind_r;
  assign out_temp      = otemp_r;
  assign out_press     = opress_r;

endmodule

`default_nettype wire

### sv/ptc_ctrl.sv
// ----------------------------------------------------------------------------
// Compensation controller
// Steps the datapath through the temperature or pressure sequence and
// owns the input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pressure_temperature_compensation_macros.svh"

module ptc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_kind,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output ptc_pkg::ptc_cmd_t       cmd,
  input  wire ptc_pkg::ptc_stat_t stat
);

  ptc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // The result register can take a beat when empty or being drained.
  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_kind == ptc_pkg::KIND_PRESS) ? ptc_pkg::S_P_V1 : ptc_pkg::S_T_DIFF;
        end
      end
      ptc_pkg::S_T_DIFF:    state_nxt = ptc_pkg::S_T_MUL_A;
      ptc_pkg::S_T_MUL_A:   state_nxt = ptc_pkg::S_T_SQR;
      ptc_pkg::S_T_SQR:     state_nxt = ptc_pkg::S_T_MUL_C;
      ptc_pkg::S_T_MUL_C:   state_nxt = ptc_pkg::S_T_FINE;
      ptc_pkg::S_T_FINE:    state_nxt = ptc_pkg::S_T_SCALE;
      ptc_pkg::S_T_SCALE:   state_nxt = ptc_pkg::S_T_ROUND;
      ptc_pkg::S_T_ROUND:   state_nxt = ptc_pkg::S_OUT;
      ptc_pkg::S_P_V1:      state_nxt = ptc_pkg::S_P_SQR;
      ptc_pkg::S_P_SQR:     state_nxt = ptc_pkg::S_P_MUL6;
      ptc_pkg::S_P_MUL6:    state_nxt = ptc_pkg::S_P_MUL5;
      ptc_pkg::S_P_MUL5:    state_nxt = ptc_pkg::S_P_ADD5;
      ptc_pkg::S_P_ADD5:    state_nxt = ptc_pkg::S_P_ADD4;
      ptc_pkg::S_P_ADD4:    state_nxt = ptc_pkg::S_P_MUL3;
      ptc_pkg::S_P_MUL3:    state_nxt = ptc_pkg::S_P_MUL2;
      ptc_pkg::S_P_MUL2:    state_nxt = ptc_pkg::S_P_SUM1;
      ptc_pkg::S_P_SUM1:    state_nxt = ptc_pkg::S_P_MUL1;
      ptc_pkg::S_P_MUL1:    state_nxt = ptc_pkg::S_P_BASE;
      ptc_pkg::S_P_BASE:    state_nxt = ptc_pkg::S_P_MUL3125;
      ptc_pkg::S_P_MUL3125: state_nxt = stat.div_zero ? ptc_pkg::S_P_ZERO : ptc_pkg::S_P_DIV_GO;
      ptc_pkg::S_P_DIV_GO:  state_nxt = ptc_pkg::S_P_DIV;
      ptc_pkg::S_P_DIV:     state_nxt = stat.div_done ? ptc_pkg::S_P_QUOT : ptc_pkg::S_P_DIV;
      ptc_pkg::S_P_QUOT:    state_nxt = ptc_pkg::S_P_SQP;
      ptc_pkg::S_P_ZERO:    state_nxt = ptc_pkg::S_OUT;
      ptc_pkg::S_P_SQP:     state_nxt = ptc_pkg::S_P_MUL9;
      ptc_pkg::S_P_MUL9:    state_nxt = ptc_pkg::S_P_MUL8;
      ptc_pkg::S_P_MUL8:    state_nxt = ptc_pkg::S_P_ADD98;
      ptc_pkg::S_P_ADD98:   state_nxt = ptc_pkg::S_P_ADD7;
      ptc_pkg::S_P_ADD7:    state_nxt = ptc_pkg::S_P_FINAL;
      ptc_pkg::S_P_FINAL:   state_nxt = ptc_pkg::S_OUT;
      ptc_pkg::S_OUT:       state_nxt = out_free ? ptc_pkg::S_IDLE : ptc_pkg::S_OUT;
      default:              state_nxt = ptc_pkg::S_IDLE;
    endcase
  end

  // Outputs: one datapath operation per state.
  always_comb begin
    cmd.op       = ptc_pkg::OP_NOP;
    cmd.capture  = 1'b0;
    cmd.load_out = 1'b0;
    in_tready    = 1'b0;
    unique case (state_r)
      ptc_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ptc_pkg::S_T_DIFF:    cmd.op = ptc_pkg::OP_T_DIFF;
      ptc_pkg::S_T_MUL_A:   cmd.op = ptc_pkg::OP_T_MUL_A;
      ptc_pkg::S_T_SQR:     cmd.op = ptc_pkg::OP_T_SQR;
      ptc_pkg::S_T_MUL_C:   cmd.op = ptc_pkg::OP_T_MUL_C;
      ptc_pkg::S_T_FINE:    cmd.op = ptc_pkg::OP_T_FINE;
      ptc_pkg::S_T_SCALE:   cmd.op = ptc_pkg::OP_T_SCALE;
      ptc_pkg::S_T_ROUND:   cmd.op = ptc_pkg::OP_T_ROUND;
      ptc_pkg::S_P_V1:      cmd.op = ptc_pkg::OP_P_V1;
      ptc_pkg::S_P_SQR:     cmd.op = ptc_pkg::OP_P_SQR;
      ptc_pkg::S_P_MUL6:    cmd.op = ptc_pkg::OP_P_MUL6;
      ptc_pkg::S_P_MUL5:    cmd.op = ptc_pkg::OP_P_MUL5;
      ptc_pkg::S_P_ADD5:    cmd.op = ptc_pkg::OP_P_ADD5;
      ptc_pkg::S_P_ADD4:    cmd.op = ptc_pkg::OP_P_ADD4;
      ptc_pkg::S_P_MUL3:    cmd.op = ptc_pkg::OP_P_MUL3;
      ptc_pkg::S_P_MUL2:    cmd.op = ptc_pkg::OP_P_MUL2;
      ptc_pkg::S_P_SUM1:    cmd.op = ptc_pkg::OP_P_SUM1;
      ptc_pkg::S_P_MUL1:    cmd.op = ptc_pkg::OP_P_MUL1;
      ptc_pkg::S_P_BASE:    cmd.op = ptc_pkg::OP_P_BASE;
      ptc_pkg::S_P_MUL3125: cmd.op = ptc_pkg::OP_P_MUL3125;
      ptc_pkg::S_P_DIV_GO:  cmd.op = ptc_pkg::OP_P_DIV_GO;
      ptc_pkg::S_P_QUOT:    cmd.op = ptc_pkg::OP_P_QUOT;
      ptc_pkg::S_P_ZERO:    cmd.op = ptc_pkg::OP_P_ZERO;
      ptc_pkg::S_P_SQP:     cmd.op = ptc_pkg::OP_P_SQP;
      ptc_pkg::S_P_MUL9:    cmd.op = ptc_pkg::OP_P_MUL9;
      ptc_pkg::S_P_MUL8:    cmd.op = ptc_pkg::OP_P_MUL8;
      ptc_pkg::S_P_ADD98:   cmd.op = ptc_pkg::OP_P_ADD98;
      ptc_pkg::S_P_ADD7:    cmd.op = ptc_pkg::OP_P_ADD7;
      ptc_pkg::S_P_FINAL:   cmd.op = ptc_pkg::OP_P_FINAL;
      ptc_pkg::S_OUT:       cmd.load_out = out_free;
      default:              cmd.op = ptc_pkg::OP_NOP;
    endcase
  end

  // Result valid: set when a beat is loaded, cleared when it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // A new item is never taken in the cycle a result is loaded.
  `PTC_ASSERT(a_ctrl_accept_vs_load, in_tready |-> !cmd.load_out, "accept and load overlap")
  // The divider only finishes while the controller waits for it.
  `PTC_ASSERT(a_ctrl_div_done_wait, stat.div_done |-> (state_r == ptc_pkg::S_P_DIV), "stray divider done")
  // A loaded result is not overwritten before it is taken.
  `PTC_ASSERT(a_ctrl_no_overwrite, (out_valid_r && !out_tready) |=> out_valid_r, "result dropped")

endmodule

`default_nettype wire

### sv/pressure_temperature_compensation.sv
// One item at a time: a new reading is taken only after the previous result has
// been loaded into the result register. Pressure items take longer than temperature
// items: they pass through the radix-4 divider and share the single multiplier,
// unless the divisor term is zero, which skips the division and the second-order
// correction.
// Reset (rst_n low, synchronous) clears the controller, trimming words and fine temperature.
// ----------------------------------------------------------------------------
// Pressure and temperature compensation
// Integer trimming compensation of 20-bit barometric sensor readings,
// built from a controller state machine and a multiplier/divider datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [ptc_pkg::IN_DATA_W-1:0]   in_tdata,   // [19:0] raw_sample, [23:20] zero
  input  wire logic                            in_tuser,   // [0] kind
  // Result stream.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [ptc_pkg::OUT_DATA_W-1:0]  out_tdata,  // [23:0] temperature_centi,
                                                           // [55:24] pressure_pa
  output logic                                 out_tuser,  // [0] result_kind
  // Configuration write channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ptc_pkg::CFG_W-1:0]       cfg_data
);

  ptc_pkg::ptc_cmd_t           cmd;
  ptc_pkg::ptc_stat_t          stat;
  logic [ptc_pkg::TEMP_W-1:0]  res_temp;
  logic [ptc_pkg::PRESS_W-1:0] res_press;

  // The user must write the registers only while idle; the block does not enforce this, so the port is always ready.
  assign cfg_ready = 1'b1;

  ptc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  ptc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (in_tuser),
    .in_raw    (in_tdata[ptc_pkg::RAW_W-1:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_kind  (out_tuser),
    .out_temp  (res_temp),
    .out_press (res_press)
  );

  // Result beat packing, temperature in the low bits.
  assign out_tdata = ptc_pkg::OUT_DATA_W'({res_press, res_temp});

endmodule

`default_nettype wire

### sim/pressure_temperature_compensation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Compensation result checker
// Watches the configuration, input and result channels of the compensation
// block. It predicts every result from its own copy of the trimming words and
// the fine temperature, then compares each result beat with the oldest
// prediction still owed.
// ----------------------------------------------------------------------------

module pressure_temperature_compensation_checker
  import ptc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,
  input  logic                    in_tuser,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [OUT_DATA_W-1:0]   out_tdata,
  input  logic                    out_tuser,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output int unsigned             mismatch_count,
  output int unsigned             results_owed,
  output int unsigned             results_checked
);

  localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic               kind;
    logic [TEMP_W-1:0]  centi;
    logic [PRESS_W-1:0] pascals;
  } reading_result_t;

  // Local copy of the trimming words and the fine temperature.
  logic [47:0]       temp_coeffs;
  logic [63:0]       press_low;
  logic [63:0]       press_high;
  logic [15:0]       press_nine;
  logic [WORD_W-1:0] fine_word;

  reading_result_t owed_results[$];
  reading_result_t want;
  reading_result_t got;

  initial begin
    mismatch_count  = 0;
    results_owed    = 0;
    results_checked = 0;
  end

  // Arithmetic right shift of a 32-bit two's complement word.
  function automatic logic [WORD_W-1:0] sar32(input logic [WORD_W-1:0] x, input int unsigned s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [WORD_W-1:0] sext16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  // Fine temperature from a raw temperature reading.
  function automatic logic [WORD_W-1:0] fine_from_raw(input logic [RAW_W-1:0] raw);
    logic [WORD_W-1:0] adc, t1, t2, t3, a, d, b;
    adc = {{(WORD_W-RAW_W){1'b0}}, raw};
    t1  = {16'd0, temp_coeffs[15:0]};
    t2  = sext16(temp_coeffs[31:16]);
    t3  = sext16(temp_coeffs[47:32]);
    a = (adc >> 3) - (t1 << 1);
    a = a * t2;
    a = sar32(a, 11);
    d = (adc >> 4) - t1;
    b = d * d;
    b = sar32(b, 12) * t3;
    b = sar32(b, 14);
    return a + b;
  endfunction

  // Hundredths of a degree, wrapped to the output width.
  function automatic logic [TEMP_W-1:0] centi_from_fine(input logic [WORD_W-1:0] fine);
    logic [WORD_W-1:0] w;
    w = fine * TEMP_SCALE + ROUND_BIAS;
    w = sar32(w, 8);
    return w[TEMP_W-1:0];
  endfunction

  // Pressure in pascals from a raw pressure reading and the fine temperature.
  function automatic logic [WORD_W-1:0] pascal_from_raw(input logic [RAW_W-1:0] raw);
    logic [WORD_W-1:0] adc, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [WORD_W-1:0] v1, v2, q, p, h;
    adc = {{(WORD_W-RAW_W){1'b0}}, raw};
    p1 = {16'd0, press_low[15:0]};
    p2 = sext16(press_low[31:16]);
    p3 = sext16(press_low[47:32]);
    p4 = sext16(press_low[63:48]);
    p5 = sext16(press_high[15:0]);
    p6 = sext16(press_high[31:16]);
    p7 = sext16(press_high[47:32]);
    p8 = sext16(press_high[63:48]);
    p9 = sext16(press_nine);

    v1 = sar32(fine_word, 1) - FINE_OFFSET;
    q  = sar32(v1, 2);
    q  = q * q;
    v2 = sar32(q, 11) * p6;
    h  = v1 * p5;
    v2 = v2 + (h << 1);
    v2 = sar32(v2, 2) + (p4 << 16);
    h  = p3 * sar32(q, 13);
    h  = sar32(h, 3) + sar32(p2 * v1, 1);
    v1 = sar32(h, 18);
    v1 = (P1_BIAS + v1) * p1;
    v1 = sar32(v1, 15);
    // A zero divisor term forces the result to zero.
    if (v1 == '0) begin
      return '0;
    end
    p = ((ADC_FULL - adc) - sar32(v2, 12)) * PRESS_SCALE;
    if (p < SIGN_BIT) begin
      p = (p << 1) / v1;
    end else begin
      p = (p / v1) * 2;
    end
    h  = (p >> 3) * (p >> 3);
    v1 = sar32(p9 * (h >> 13), 12);
    v2 = sar32((p >> 2) * p8, 13);
    return p + sar32(v1 + v2 + p7, 4);
  endfunction

  // Track configuration, predict on input beats, compare on result beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs  = '0;
      press_low    = '0;
      press_high   = '0;
      press_nine   = '0;
      fine_word    = '0;
      owed_results.delete();
      results_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TEMP_COEFFS: temp_coeffs = cfg_data[47:0];
          CFG_PRESS_LOW:   press_low   = cfg_data;
          CFG_PRESS_HIGH:  press_high  = cfg_data;
          CFG_PRESS_NINE:  press_nine  = cfg_data[15:0];
          default: ;
        endcase
      end

      // The result side goes first so that a beat never matches a
      // prediction made at the same edge.
      if (out_tvalid && out_tready) begin
        got.kind    = out_tuser;
        got.centi   = out_tdata[TEMP_W-1:0];
        got.pascals = out_tdata[TEMP_W +: PRESS_W];
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected result beat kind %0d temp %0d press %0d", $time,
                     got.kind, $signed(got.centi), got.pascals);
          end
        end else begin
          want = owed_results.pop_front();
          results_checked++;
          if (got.kind !== want.kind || got.centi !== want.centi ||
              got.pascals !== want.pascals) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: result %0d mismatch: kind %0d (want %0d), temp %0d (want %0d), press %0d (want %0d)",
                       $time, results_checked, got.kind, want.kind, $signed(got.centi),
                       $signed(want.centi), got.pascals, want.pascals);
            end
          end
        end
      end

      if (in_tvalid && in_tready) begin
        want.kind = in_tuser;
        if (in_tuser == KIND_TEMP) begin
          fine_word    = fine_from_raw(in_tdata[RAW_W-1:0]);
          want.centi   = centi_from_fine(fine_word);
          want.pascals = '0;
        end else begin
          want.centi   = '0;
          want.pascals = pascal_from_raw(in_tdata[RAW_W-1:0]);
        end
        owed_results.push_back(want);
      end

      results_owed <= owed_results.size();
    end
  end

endmodule

### sim/pressure_temperature_compensation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Compensation block testbench
// Drives temperature and pressure readings through the compensation block
// under a series of trimming settings, with random idling on both streams,
// and leaves all checking to the result checker beside the block.
// ----------------------------------------------------------------------------

module pressure_temperature_compensation_test;
  import ptc_pkg::*;

  localparam int unsigned CLK_HALF        = 6;
  localparam int unsigned RESET_CYCLES    = 3;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned PHASE_ITEMS     = 175;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam logic [RAW_W-1:0] RAW_MAX    = '1;

  // Typical trimming words: {T3, T2, T1}, {P4, P3, P2, P1}, {P8, P7, P6, P5}, P9.
  localparam logic [47:0] TYP_TEMP  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_LOW   = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_HIGH  = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [15:0] TYP_NINE  = 16'd6000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_ready;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned results_checked;
  int unsigned temp_sent      = 0;
  int unsigned press_sent     = 0;
  int unsigned settings_used  = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned quiet_cycles   = 0;
  logic        hold_req       = 1'b0;
  logic        hold_taken     = 1'b0;

  pressure_temperature_compensation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pressure_temperature_compensation_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed),
    .results_checked (results_checked)
  );

  // Clock.
  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: too long without any beat on any channel ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one reading and returns once it is accepted; valid stays high.
  task automatic send_reading(input logic kind, input logic [RAW_W-1:0] raw);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_DATA_W-RAW_W){1'b0}}, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == KIND_TEMP) begin
      temp_sent++;
    end else begin
      press_sent++;
    end
  endtask

  // Random idle cycles on the input side after a beat.
  task automatic sender_gap();
    int unsigned gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Writes all four trimming registers; only called while the block is idle.
  task automatic apply_setting(input logic [63:0] temp_w, input logic [63:0] low_w,
                               input logic [63:0] high_w, input logic [63:0] nine_w);
    logic [63:0] words [4];
    words[CFG_TEMP_COEFFS] = temp_w;
    words[CFG_PRESS_LOW]   = low_w;
    words[CFG_PRESS_HIGH]  = high_w;
    words[CFG_PRESS_NINE]  = nine_w;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Trimming setting of a random phase; extremes and typical values mixed in.
  task automatic apply_phase_setting(input int unsigned phase);
    logic [15:0] noise;
    noise = 16'($urandom);
    case (phase)
      0: apply_setting({noise, TYP_TEMP}, TYP_LOW, TYP_HIGH,
                       (rand64() & ~64'hFFFF) | {48'd0, TYP_NINE});
      2: apply_setting('1, '1, '1, '1);
      4: apply_setting({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
      5: apply_setting('0, '0, '0, '0);
      6: apply_setting({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
      7: apply_setting({noise, TYP_TEMP}, TYP_LOW, {rand64() & 64'hFFFF_0000_FFFF_FFFF} |
                       {TYP_HIGH & 64'h0000_FFFF_0000_0000}, rand64());
      default: apply_setting(rand64(), rand64(), rand64(), rand64());
    endcase
  endtask

  // One random reading: full-range, typical-range or extreme raw values.
  task automatic send_random_reading();
    logic             kind;
    logic [RAW_W-1:0] raw;
    kind = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       raw = '0;
      1:       raw = RAW_MAX;
      2, 3:    raw = RAW_W'(300000 + $urandom_range(300000));
      default: raw = RAW_W'($urandom);
    endcase
    send_reading(kind, raw);
    sender_gap();
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset trimming words: a pressure reading ahead of any temperature
    // reading sees a zero fine temperature and a zero divisor term.
    send_reading(KIND_PRESS, '0);
    send_reading(KIND_PRESS, RAW_MAX);
    send_reading(KIND_TEMP, RAW_MAX);
    send_reading(KIND_PRESS, 20'd415148);
    drain();

    // Typical trimming words, field extremes and both kinds.
    apply_setting({16'd0, TYP_TEMP}, TYP_LOW, TYP_HIGH, {48'd0, TYP_NINE});
    send_reading(KIND_TEMP, 20'd519888);
    send_reading(KIND_PRESS, 20'd415148);
    send_reading(KIND_PRESS, '0);
    send_reading(KIND_PRESS, RAW_MAX);
    send_reading(KIND_TEMP, '0);
    send_reading(KIND_PRESS, 20'd415148);
    send_reading(KIND_TEMP, RAW_MAX);
    send_reading(KIND_PRESS, 20'h55555);
    send_reading(KIND_TEMP, 20'hAAAAA);
    send_reading(KIND_PRESS, 20'hAAAAA);
    send_reading(KIND_TEMP, 20'h55555);
    send_reading(KIND_PRESS, 20'h80000);
    send_reading(KIND_PRESS, 20'h7FFFF);
    drain();

    // Random phases: output idles then input idles, later neither.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        tx_idle_pct = 29;
        rx_idle_pct = 87;
      end else if (phase < 6) begin
        tx_idle_pct = 87;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apply_phase_setting(phase);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the result side off so the block fills and stalls its input.
        if (phase == 6 && n == 40) begin
          hold_req <= ~hold_req;
        end
        // Pause the input side mid-phase until everything has come back.
        if (n == PHASE_ITEMS / 2) begin
          drain();
        end
        send_random_reading();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d temperature and %0d pressure beats under %0d trimming settings",
             temp_sent, press_sent, settings_used);
    $display("%0d results compared, with input and output idling and a %0d-cycle hold-off",
             results_checked, HOLD_OFF_CYCLES);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
